/* rtl/core/heading_table_correction_macros.svh */
`ifndef HEADING_TABLE_CORRECTION_MACROS_SVH
`define HEADING_TABLE_CORRECTION_MACROS_SVH

// same-cycle implication, checked on every clk edge outside reset
`define HTC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HTC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/htc_pkg.sv */
package htc_pkg;

	localparam int MAX_POINTS = 16;
	localparam int PIDX_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = 5;
	localparam int ANG_W      = 16;
	localparam int HEAD_W     = 24;
	localparam int IN_W       = 64;

	localparam int FULL_TURN  = 46080;
	localparam int HALF_TURN  = 23040;
	localparam int MIN_SPAN   = 1;

	// heading reduction: restoring steps against turn multiples
	localparam int WRAP_STEPS = 8;
	localparam int STEP_W     = $clog2(WRAP_STEPS);

	// interpolation datapath
	localparam int DIFF_W     = 18;
	localparam int MAG_W      = 15;
	localparam int PROD_W     = ANG_W + MAG_W;
	localparam int DIV_W      = 32;
	localparam int QUO_W      = 16;
	localparam int QCNT_W     = $clog2(QUO_W);

	localparam logic [ANG_W-1:0]         TURN_ANG  = ANG_W'(FULL_TURN);
	localparam logic [ANG_W-1:0]         MIN_SPAN_A = ANG_W'(MIN_SPAN);
	localparam logic [HEAD_W-1:0]        TURN_WIDE = HEAD_W'(FULL_TURN);
	localparam logic [HEAD_W-1:0]        WRAP_BIAS = HEAD_W'(FULL_TURN * (2 ** WRAP_STEPS));
	localparam logic [HEAD_W-1:0]        WRAP_TOP  = HEAD_W'(FULL_TURN * (2 ** (WRAP_STEPS - 1)));
	localparam logic signed [DIFF_W-1:0] TURN_D    = DIFF_W'(FULL_TURN);
	localparam logic signed [DIFF_W-1:0] HALF_D    = DIFF_W'(HALF_TURN);

	// scan token handed from cell to cell
	typedef struct packed {
		logic [ANG_W-1:0] h;
		logic             found;
		logic [ANG_W-1:0] r0;
		logic [ANG_W-1:0] span;
		logic [ANG_W-1:0] c0;
		logic [ANG_W-1:0] c1;
	} tok_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRAP,
		ST_SCAN,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

/* rtl/core/heading_table_correction.sv */
// Corrects a compass heading (1/128 degree units, 46080 per turn) through up to 16
// calibration points held in a row of cells. A write transaction (tuser 0) stores one
// point. A correction transaction (tuser 1) first reduces the heading into one turn.
// The scan token then passes through the 16 cells and is captured, and the offset is
// multiplied. The divider is loaded and rounds the interpolation step at one quotient bit
// per cycle. The result is then finished and loaded into the output register. A heading
// that is passed through skips the divider. One item is worked on at a time. The next
// item can be accepted in the cycle after the result is loaded, and a finished result
// waits in the output register while that item is accepted. Write point_count only
// while no correction is in progress.
`include "heading_table_correction_macros.svh"

module heading_table_correction (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [htc_pkg::CNT_W-1:0]  cfg_data,   // point_count
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [htc_pkg::IN_W-1:0]   s_tdata,    // point_index, point_raw, point_corr, raw_heading
	input  logic                       s_tuser,    // mode
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [htc_pkg::ANG_W-1:0]  m_tdata,    // corrected_heading
	output logic                       m_tuser     // interpolated
);

	localparam int N = htc_pkg::MAX_POINTS;
	localparam int AW = htc_pkg::ANG_W;

	htc_pkg::state_t state_q, state_d;

	logic [htc_pkg::CNT_W-1:0]  count_q;
	logic [htc_pkg::HEAD_W-1:0] acc_q;
	logic [htc_pkg::HEAD_W-1:0] turn_q;
	logic [htc_pkg::STEP_W-1:0] step_q;
	logic                       go_q;
	htc_pkg::tok_t              res_q;
	logic [htc_pkg::PROD_W-1:0] mag_q;
	logic                       neg_q;
	logic [AW-1:0]              out_h_q;
	logic                       out_i_q;
	logic                       m_tvalid_q;
	logic [AW-1:0]              m_tdata_q;
	logic                       m_tuser_q;

	logic                       s_xfer;
	logic                       wrap_last;
	logic                       narrow;
	logic                       out_ld;

	logic [htc_pkg::PIDX_W-1:0] wr_idx;

	logic [htc_pkg::HEAD_W-1:0] head_in;

	htc_pkg::tok_t              tok_head;
	logic                       chain_vld [0:N];
	htc_pkg::tok_t              chain_tok [0:N];
	logic [N:0]                 chain_vec;
	logic [AW-1:0]              pt_raw  [0:N-1];
	logic [AW-1:0]              pt_corr [0:N-1];
	logic [N-1:0]               pair_en;
	logic [N-1:0]               wr_sel;

	logic signed [htc_pkg::DIFF_W-1:0] d0, d1, d2, dabs;
	logic [AW-1:0]                     offset;
	logic [htc_pkg::DIV_W-1:0]         dividend;
	logic                              div_done;
	logic [htc_pkg::QUO_W-1:0]         quo;
	logic signed [htc_pkg::DIFF_W-1:0] qs, sum, sum_w;

	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign wr_idx    = s_tdata[htc_pkg::PIDX_W-1:0];
	assign head_in   = s_tdata[59:36];
	assign wrap_last = step_q == htc_pkg::STEP_W'(htc_pkg::WRAP_STEPS - 1);
	assign narrow    = !res_q.found || (res_q.span <= htc_pkg::MIN_SPAN_A);
	assign out_ld    = (state_q == htc_pkg::ST_FIN) && (!m_tvalid_q || m_tready);

	// cell row
	assign chain_vld[0] = go_q;
	always_comb begin
		tok_head       = '0;
		tok_head.h     = acc_q[AW-1:0];
		tok_head.found = 1'b0;
	end
	assign chain_tok[0] = tok_head;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [AW-1:0] nraw;
		logic [AW-1:0] ncorr;
		if (i < N - 1) begin : g_mid
			assign pair_en[i] = htc_pkg::CNT_W'(i + 1) < count_q;
			assign nraw       = pt_raw[i+1];
			assign ncorr      = pt_corr[i+1];
		end else begin : g_end
			assign pair_en[i] = 1'b0;
			assign nraw       = '0;
			assign ncorr      = '0;
		end
		assign wr_sel[i] = s_xfer && !s_tuser && (wr_idx == htc_pkg::PIDX_W'(i));

		htc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.wr_en       (wr_sel[i]),
			.wr_raw      (s_tdata[19:4]),
			.wr_corr     (s_tdata[35:20]),
			.pair_en     (pair_en[i]),
			.nxt_raw     (nraw),
			.nxt_corr    (ncorr),
			.pt_raw      (pt_raw[i]),
			.pt_corr     (pt_corr[i]),
			.tok_vld_in  (chain_vld[i]),
			.tok_in      (chain_tok[i]),
			.tok_vld_out (chain_vld[i+1]),
			.tok_out     (chain_tok[i+1])
		);
	end

	for (genvar i = 0; i <= N; i++) begin : g_vec
		assign chain_vec[i] = chain_vld[i];
	end

	// shorter-way difference and interpolation offset
	always_comb begin
		d0 = $signed({2'b00, res_q.c1}) - $signed({2'b00, res_q.c0});
		d1 = (d0 > htc_pkg::HALF_D) ? d0 - htc_pkg::TURN_D : d0;
		d2 = (d1 < -htc_pkg::HALF_D) ? d1 + htc_pkg::TURN_D : d1;
		dabs = d2[htc_pkg::DIFF_W-1] ? -d2 : d2;
		offset = res_q.h - res_q.r0;
	end

	assign dividend = {1'b0, mag_q} + htc_pkg::DIV_W'(res_q.span >> 1);

	htc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == htc_pkg::ST_DIV_GO),
		.dividend (dividend),
		.divisor  (res_q.span),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		qs    = neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
		sum   = $signed({2'b00, res_q.c0}) + qs;
		sum_w = sum;
		if (sum < 0) begin
			sum_w = sum + htc_pkg::TURN_D;
		end else if (sum >= htc_pkg::TURN_D) begin
			sum_w = sum - htc_pkg::TURN_D;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			htc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser) begin
					state_d = htc_pkg::ST_WRAP;
				end
			end
			htc_pkg::ST_WRAP: begin
				if (wrap_last) begin
					state_d = htc_pkg::ST_SCAN;
				end
			end
			htc_pkg::ST_SCAN: begin
				if (chain_vld[N]) begin
					state_d = htc_pkg::ST_MUL;
				end
			end
			htc_pkg::ST_MUL: begin
				state_d = narrow ? htc_pkg::ST_FIN : htc_pkg::ST_DIV_GO;
			end
			htc_pkg::ST_DIV_GO: begin
				state_d = htc_pkg::ST_DIV;
			end
			htc_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = htc_pkg::ST_FIN;
				end
			end
			htc_pkg::ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = htc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = htc_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			step_q     <= '0;
			go_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (s_xfer) begin
				step_q <= '0;
			end else if (state_q == htc_pkg::ST_WRAP) begin
				step_q <= step_q + 1'b1;
			end
			go_q <= (state_q == htc_pkg::ST_WRAP) && wrap_last;
			if (out_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			htc_pkg::ST_IDLE: begin
				if (s_xfer) begin
					acc_q  <= head_in[htc_pkg::HEAD_W-1] ? head_in + htc_pkg::WRAP_BIAS : head_in;
					turn_q <= htc_pkg::WRAP_TOP;
				end
			end
			htc_pkg::ST_WRAP: begin
				if (acc_q >= turn_q) begin
					acc_q <= acc_q - turn_q;
				end
				turn_q <= turn_q >> 1;
			end
			htc_pkg::ST_SCAN: begin
				if (chain_vld[N]) begin
					res_q <= chain_tok[N];
				end
			end
			htc_pkg::ST_MUL: begin
				mag_q   <= htc_pkg::PROD_W'(offset) *
					htc_pkg::PROD_W'(dabs[htc_pkg::MAG_W-1:0]);
				neg_q   <= d2[htc_pkg::DIFF_W-1];
				out_h_q <= res_q.h;
				out_i_q <= 1'b0;
			end
			htc_pkg::ST_DIV: begin
				if (div_done) begin
					out_h_q <= sum_w[AW-1:0];
					out_i_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (out_ld) begin
			m_tdata_q <= out_h_q;
			m_tuser_q <= out_i_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`HTC_ASSERT_IMP(a_out_range, m_tvalid_q, m_tdata_q < htc_pkg::TURN_ANG, "result outside one turn")
	`HTC_ASSERT_IMP(a_one_token, 1'b1, $onehot0(chain_vec), "more than one scan token in the cell row")
	`HTC_ASSERT_IMP(a_div_state, div_done, state_q == htc_pkg::ST_DIV, "divider finished outside its wait state")
	`HTC_ASSERT_IMP(a_wrap_done, go_q, acc_q < htc_pkg::TURN_WIDE, "heading not reduced before the scan")
	`HTC_ASSERT_NXT(a_write_idle, s_xfer && !s_tuser, state_q == htc_pkg::ST_IDLE, "write transaction left idle")

endmodule

/* rtl/core/htc_cell.sv */
module htc_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [htc_pkg::ANG_W-1:0] wr_raw,
	input  logic [htc_pkg::ANG_W-1:0] wr_corr,
	input  logic                     pair_en,
	input  logic [htc_pkg::ANG_W-1:0] nxt_raw,
	input  logic [htc_pkg::ANG_W-1:0] nxt_corr,
	output logic [htc_pkg::ANG_W-1:0] pt_raw,
	output logic [htc_pkg::ANG_W-1:0] pt_corr,
	input  logic                     tok_vld_in,
	input  htc_pkg::tok_t            tok_in,
	output logic                     tok_vld_out,
	output htc_pkg::tok_t            tok_out
);

	logic [htc_pkg::ANG_W-1:0] raw_q;
	logic [htc_pkg::ANG_W-1:0] corr_q;
	logic                      vld_q;
	htc_pkg::tok_t             tok_q;
	htc_pkg::tok_t             tok_d;
	logic                      hit;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			raw_q  <= wr_raw;
			corr_q <= wr_corr;
		end
	end

	// first bracketing pair claims the token
	assign hit = !tok_in.found && pair_en && (tok_in.h >= raw_q) && (tok_in.h <= nxt_raw);

	always_comb begin
		tok_d = tok_in;
		if (hit) begin
			tok_d.found = 1'b1;
			tok_d.r0    = raw_q;
			tok_d.span  = nxt_raw - raw_q;
			tok_d.c0    = corr_q;
			tok_d.c1    = nxt_corr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_vld_in) begin
			tok_q <= tok_d;
		end
	end

	assign pt_raw      = raw_q;
	assign pt_corr     = corr_q;
	assign tok_vld_out = vld_q;
	assign tok_out     = tok_q;

endmodule

/* rtl/core/htc_div.sv */
module htc_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [htc_pkg::DIV_W-1:0] dividend,
	input  logic [htc_pkg::ANG_W-1:0] divisor,
	output logic                     done,
	output logic [htc_pkg::QUO_W-1:0] quotient
);

	logic [htc_pkg::DIV_W-1:0]  rem_q;
	logic [htc_pkg::DIV_W-1:0]  dsr_q;
	logic [htc_pkg::QUO_W-1:0]  quo_q;
	logic [htc_pkg::QCNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       ge;

	assign ge = rem_q >= dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == htc_pkg::QCNT_W'(htc_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, msb first
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= htc_pkg::DIV_W'({divisor, {(htc_pkg::QUO_W - 1){1'b0}}});
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsr_q;
			end
			quo_q <= {quo_q[htc_pkg::QUO_W-2:0], ge};
			dsr_q <= dsr_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
